/* rtl/assert_macros.svh */
// Assertion helpers, clocked on clk and held off during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/efsd_pkg.sv */
package efsd_pkg;

  localparam int SERVERS_DEF = 16;
  localparam int CFG_W       = 5;
  localparam int TIME_W      = 32;
  localparam int LOAD_W      = 16;
  localparam int FT_W        = 33;
  localparam int TOT_W       = 48;
  localparam int SRV_W       = 5;
  localparam int ENTRY_W     = FT_W + TOT_W;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

  localparam logic KIND_JOB    = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_DECIDE,
    ST_RPT_RD,
    ST_RPT_CK,
    ST_RPT_FIN
  } ctl_state_t;

  typedef struct packed {
    logic latch;
    logic scan_clr;
    logic scan_rd;
    logic job_fin;
    logic rpt_rd;
    logic rpt_take;
    logic rpt_fin;
  } ctl_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic rpt_match;
    logic pend_valid;
    logic out_free;
  } dp_status_t;

endpackage

/* rtl/efsd_req_if.sv */
interface efsd_req_if;
  import efsd_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  logic [TIME_W-1:0] start_time;
  logic [LOAD_W-1:0] job_load;

  modport source (output valid, kind, start_time, job_load, input ready);
  modport sink (input valid, kind, start_time, job_load, output ready);
endinterface

/* rtl/efsd_rsp_if.sv */
interface efsd_rsp_if;
  import efsd_pkg::*;

  logic             valid;
  logic             ready;
  logic [SRV_W-1:0] server;
  logic             accepted;
  logic [TOT_W-1:0] total_load;
  logic             last;

  modport source (output valid, server, accepted, total_load, last, input ready);
  modport sink (input valid, server, accepted, total_load, last, output ready);
endinterface

/* rtl/efsd_ram.sv */
module efsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/efsd_ctrl.sv */
module efsd_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  input  logic                  req_kind,
  output logic                  req_ready,
  input  efsd_pkg::dp_status_t  status,
  output efsd_pkg::ctl_cmd_t    cmd
);
  import efsd_pkg::*;

  ctl_state_t state;
  ctl_state_t state_next;
  logic       accept;
  logic       rpt_stall;

  assign accept    = req_valid && (state == ST_IDLE);
  assign rpt_stall = status.rpt_match && status.pend_valid && !status.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (req_kind == KIND_REPORT) ? ST_RPT_RD : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.scan_last) begin
          state_next = ST_SCAN_END;
        end
      end
      ST_SCAN_END: state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_RPT_RD: state_next = ST_RPT_CK;
      ST_RPT_CK: begin
        if (!rpt_stall) begin
          state_next = status.scan_last ? ST_RPT_FIN : ST_RPT_RD;
        end
      end
      ST_RPT_FIN: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready    = 1'b1;
        cmd.latch    = accept;
        cmd.scan_clr = accept;
      end
      ST_SCAN:    cmd.scan_rd  = 1'b1;
      ST_DECIDE:  cmd.job_fin  = status.out_free;
      ST_RPT_RD:  cmd.rpt_rd   = 1'b1;
      ST_RPT_CK:  cmd.rpt_take = !rpt_stall;
      ST_RPT_FIN: cmd.rpt_fin  = status.out_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

/* rtl/efsd_datapath.sv */
`include "assert_macros.svh"

module efsd_datapath #(
  parameter int SERVERS = efsd_pkg::SERVERS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [efsd_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic [efsd_pkg::TIME_W-1:0]   req_start_time,
  input  logic [efsd_pkg::LOAD_W-1:0]   req_job_load,
  input  efsd_pkg::ctl_cmd_t            cmd,
  output efsd_pkg::dp_status_t          status,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output logic [efsd_pkg::SRV_W-1:0]    rsp_server,
  output logic                          rsp_accepted,
  output logic [efsd_pkg::TOT_W-1:0]    rsp_total_load,
  output logic                          rsp_last
);
  import efsd_pkg::*;

  localparam int IDX_W = (SERVERS > 1) ? $clog2(SERVERS) : 1;
  localparam int CNT_W = $clog2(SERVERS + 1);

  logic [CFG_W-1:0]   server_count;
  logic [CNT_W-1:0]   active_n;
  logic [IDX_W-1:0]   last_idx;

  logic [TIME_W-1:0]  start_q;
  logic [LOAD_W-1:0]  load_q;

  logic [IDX_W-1:0]   cnt;
  logic               rd_vld_q;
  logic [IDX_W-1:0]   rd_idx_q;
  logic [SERVERS-1:0] vld;

  logic               ram_we;
  logic               ram_re;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [FT_W-1:0]    cur_ft;
  logic [TOT_W-1:0]   cur_tot;

  logic               best_has;
  logic [IDX_W-1:0]   best_idx;
  logic [FT_W-1:0]    best_ft;
  logic [TOT_W-1:0]   best_tot;
  logic [TOT_W-1:0]   highest;

  logic               pend_valid;
  logic [IDX_W-1:0]   pend_idx;
  logic [TOT_W-1:0]   pend_tot;

  logic               drop;
  logic [TOT_W:0]     sum_wide;
  logic [TOT_W-1:0]   sum_sat;
  logic [FT_W-1:0]    ft_new;
  logic               match;
  logic               out_free;
  logic               out_load;
  logic [SRV_W-1:0]   out_server;
  logic               out_accepted;
  logic [TOT_W-1:0]   out_total;
  logic               out_last;

  // Clamp the programmed count into 1..SERVERS.
  always_comb begin
    if (server_count == '0) begin
      active_n = CNT_W'(1);
    end else if (32'(server_count) > SERVERS) begin
      active_n = CNT_W'(SERVERS);
    end else begin
      active_n = CNT_W'(server_count);
    end
  end
  assign last_idx = IDX_W'(active_n - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      server_count <= CFG_RESET;
    end else if (cfg_we) begin
      server_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      start_q <= req_start_time;
      load_q  <= req_job_load;
    end
  end

  // Entries never written read as zero.
  assign cur_ft  = vld[rd_idx_q] ? ram_rdata[ENTRY_W-1:TOT_W] : '0;
  assign cur_tot = vld[rd_idx_q] ? ram_rdata[TOT_W-1:0] : '0;

  assign sum_wide = {1'b0, best_tot} + (TOT_W + 1)'(load_q);
  assign sum_sat  = sum_wide[TOT_W] ? '1 : sum_wide[TOT_W-1:0];
  assign ft_new   = FT_W'(start_q) + FT_W'(load_q);
  assign drop     = best_ft > {1'b0, start_q};
  assign match    = cur_tot == highest;

  assign ram_re    = cmd.scan_rd || cmd.rpt_rd;
  assign ram_we    = cmd.job_fin && !drop;
  assign ram_wdata = {ft_new, sum_sat};

  efsd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SERVERS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (best_idx),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (cnt),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      rd_vld_q <= 1'b0;
      highest  <= '0;
    end else begin
      rd_vld_q <= cmd.scan_rd;
      if (ram_we) begin
        vld[best_idx] <= 1'b1;
        if (sum_sat > highest) begin
          highest <= sum_sat;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd_idx_q <= cnt;
    end
    if (cmd.scan_clr) begin
      cnt <= '0;
    end else if (cmd.scan_rd || cmd.rpt_take) begin
      cnt <= cnt + IDX_W'(1);
    end
  end

  // Running minimum of free time; strict compare keeps the lowest index on a tie.
  always_ff @(posedge clk) begin
    if (rst) begin
      best_has <= 1'b0;
    end else if (cmd.scan_clr) begin
      best_has <= 1'b0;
    end else if (rd_vld_q && (!best_has || cur_ft < best_ft)) begin
      best_has <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld_q && (!best_has || cur_ft < best_ft)) begin
      best_idx <= rd_idx_q;
      best_ft  <= cur_ft;
      best_tot <= cur_tot;
    end
  end

  // Hold the latest match until the next one shows whether it is the last.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.scan_clr) begin
      pend_valid <= 1'b0;
    end else if (cmd.rpt_take && match) begin
      pend_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rpt_take && match) begin
      pend_idx <= rd_idx_q;
      pend_tot <= cur_tot;
    end
  end

  assign out_free = !rsp_valid || rsp_ready;
  assign out_load = cmd.job_fin || cmd.rpt_fin || (cmd.rpt_take && match && pend_valid);

  always_comb begin
    out_server   = '0;
    out_accepted = 1'b0;
    out_total    = '0;
    out_last     = 1'b1;
    if (cmd.job_fin) begin
      if (!drop) begin
        out_server   = SRV_W'(32'(best_idx) + 32'd1);
        out_accepted = 1'b1;
        out_total    = sum_sat;
      end
    end else if (pend_valid) begin
      out_server   = SRV_W'(32'(pend_idx) + 32'd1);
      out_accepted = 1'b1;
      out_total    = pend_tot;
      out_last     = cmd.rpt_fin;
    end else begin
      out_total = highest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp_server     <= out_server;
      rsp_accepted   <= out_accepted;
      rsp_total_load <= out_total;
      rsp_last       <= out_last;
    end
  end

  assign status.scan_last  = cnt == last_idx;
  assign status.rpt_match  = match;
  assign status.pend_valid = pend_valid;
  assign status.out_free   = out_free;

  `ASSERT_SAME(a_load_needs_room, out_load, out_free)
  `ASSERT_SAME(a_write_with_result, ram_we, out_load && out_accepted)
  `ASSERT_NEXT(a_highest_covers_write, ram_we, highest >= $past(sum_sat))

endmodule

/* rtl/earliest_free_server_dispatch.sv */
// Job: one word in, one result; the free-time scan reads one RAM entry per
//   cycle, and the result then waits for room in the output register.
// Report: one read-and-check pair per entry; a check stalls while a held match
//   waits for room in the output register. The next word is taken while a result
//   waits. Synchronous active-high reset clears all server state at once (valid bits),
//   server count returns to 16.
module earliest_free_server_dispatch #(
  parameter int SERVERS = efsd_pkg::SERVERS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [efsd_pkg::CFG_W-1:0] cfg_wdata,
  efsd_req_if.sink                   req,
  efsd_rsp_if.source                 rsp
);
  import efsd_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;

  efsd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_kind  (req.kind),
    .req_ready (req.ready),
    .status    (status),
    .cmd       (cmd)
  );

  efsd_datapath #(
    .SERVERS (SERVERS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .req_start_time (req.start_time),
    .req_job_load   (req.job_load),
    .cmd            (cmd),
    .status         (status),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_server     (rsp.server),
    .rsp_accepted   (rsp.accepted),
    .rsp_total_load (rsp.total_load),
    .rsp_last       (rsp.last)
  );

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;
  import efsd_pkg::*;

  typedef struct packed {
    logic              kind;
    logic [TIME_W-1:0] start;
    logic [LOAD_W-1:0] load;
  } job_word_t;

  typedef struct packed {
    logic [SRV_W-1:0] server;
    logic             accepted;
    logic [TOT_W-1:0] total;
    logic             last;
  } outcome_t;

  localparam logic [TOT_W:0] TOTAL_CAP = {1'b0, {TOT_W{1'b1}}};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  logic              req_valid = 1'b0;
  logic              req_kind = 1'b0;
  logic [TIME_W-1:0] req_start = '0;
  logic [LOAD_W-1:0] req_load = '0;
  logic              rsp_ready = 1'b0;

  efsd_req_if req_ch ();
  efsd_rsp_if rsp_ch ();

  assign req_ch.valid      = req_valid;
  assign req_ch.kind       = req_kind;
  assign req_ch.start_time = req_start;
  assign req_ch.job_load   = req_load;
  assign rsp_ch.ready      = rsp_ready;

  earliest_free_server_dispatch u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  always #5 clk = ~clk;

  // Dispatcher state as the block should hold it.
  logic [CFG_W-1:0]  srv_count = CFG_RESET;
  logic [FT_W-1:0]   free_at [SERVERS_DEF];
  logic [TOT_W-1:0]  load_sum [SERVERS_DEF];
  logic [TOT_W-1:0]  top_load = '0;

  job_word_t   pending_words [$];
  outcome_t    outcome_q [$];
  int          fails = 0;
  bit          quiet = 1'b0;
  bit          hold_armed = 1'b0;
  bit          hold_taken = 1'b0;
  int          gap_left = 0;
  int          stall_left = 0;
  int          hold_left = 0;
  logic [TIME_W-1:0] stamp = '0;

  initial begin
    for (int i = 0; i < SERVERS_DEF; i++) begin
      free_at[i]  = '0;
      load_sum[i] = '0;
    end
  end

  function automatic void dispatch_word(job_word_t w);
    int             n;
    int             best;
    int             hits;
    logic [TOT_W:0] sum;
    outcome_t       o;
    if (srv_count == 0) n = 1;
    else if (srv_count > SERVERS_DEF) n = SERVERS_DEF;
    else n = int'(srv_count);
    if (w.kind == KIND_JOB) begin
      best = 0;
      for (int i = 1; i < n; i++) begin
        if (free_at[i] < free_at[best]) best = i;
      end
      if (free_at[best] > {1'b0, w.start}) begin
        o.server = '0; o.accepted = 1'b0; o.total = '0; o.last = 1'b1;
      end else begin
        sum = {1'b0, load_sum[best]} + (TOT_W + 1)'(w.load);
        if (sum > TOTAL_CAP) sum = TOTAL_CAP;
        load_sum[best] = sum[TOT_W-1:0];
        if (load_sum[best] > top_load) top_load = load_sum[best];
        free_at[best] = {1'b0, w.start} + FT_W'(w.load);
        o.server = SRV_W'(best + 1); o.accepted = 1'b1;
        o.total = load_sum[best]; o.last = 1'b1;
      end
      outcome_q = {outcome_q, o};
    end else begin
      hits = 0;
      for (int i = 0; i < n; i++) begin
        if (load_sum[i] == top_load) begin
          o.server = SRV_W'(i + 1); o.accepted = 1'b1;
          o.total = load_sum[i]; o.last = 1'b0;
          outcome_q = {outcome_q, o};
          hits++;
        end
      end
      if (hits == 0) begin
        o.server = '0; o.accepted = 1'b0; o.total = top_load; o.last = 1'b1;
        outcome_q = {outcome_q, o};
      end else begin
        outcome_q[outcome_q.size()-1].last = 1'b1;
      end
    end
  endfunction

  // Request side: hold a word until taken, otherwise idle in bursts.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      gap_left  <= 0;
    end else begin
      if (req_valid && req_ch.ready) begin
        dispatch_word(pending_words.pop_front());
      end
      if (req_valid && !req_ch.ready) begin
        // hold the offered word
      end else if (gap_left != 0) begin
        gap_left  <= gap_left - 1;
        req_valid <= 1'b0;
      end else if (pending_words.size() != 0 && !quiet && $urandom_range(0, 4) == 0) begin
        gap_left  <= $urandom_range(0, 6);
        req_valid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        req_valid <= 1'b1;
        req_kind  <= pending_words[0].kind;
        req_start <= pending_words[0].start;
        req_load  <= pending_words[0].load;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Result side: check each word, stall in bursts, one long hold-off on request.
  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      rsp_ready  <= 1'b0;
      stall_left <= 0;
      hold_left  <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ready) begin
        if (outcome_q.size() == 0) begin
          $error("result word with nothing outstanding: server %0d", rsp_ch.server);
          fails++;
        end else begin
          want = outcome_q.pop_front();
          if (rsp_ch.server !== want.server) begin
            $error("server: expected %0d, got %0d", want.server, rsp_ch.server);
            fails++;
          end
          if (rsp_ch.accepted !== want.accepted) begin
            $error("accepted: expected %0d, got %0d", want.accepted, rsp_ch.accepted);
            fails++;
          end
          if (rsp_ch.total_load !== want.total) begin
            $error("total_load: expected %0d, got %0d", want.total, rsp_ch.total_load);
            fails++;
          end
          if (rsp_ch.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, rsp_ch.last);
            fails++;
          end
        end
      end
      if (hold_armed && !hold_taken) begin
        hold_taken <= 1'b1;
        hold_left  <= 400;
        rsp_ready  <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        rsp_ready  <= 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        stall_left <= $urandom_range(0, 6);
        rsp_ready  <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  function automatic void queue_job(logic [TIME_W-1:0] s, logic [LOAD_W-1:0] l);
    job_word_t w;
    w.kind = KIND_JOB; w.start = s; w.load = l;
    pending_words = {pending_words, w};
  endfunction

  function automatic void queue_report();
    job_word_t w;
    // start and load carry noise; the block must ignore them
    w.kind = KIND_REPORT; w.start = $urandom; w.load = LOAD_W'($urandom);
    pending_words = {pending_words, w};
  endfunction

  task automatic settle();
    while (pending_words.size() != 0 || outcome_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_servers(logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    srv_count = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_run(int count);
    logic [TIME_W-1:0] s;
    logic [LOAD_W-1:0] l;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 4) == 0) begin
        queue_report();
      end else begin
        stamp = stamp + $urandom_range(0, 3000);
        s = stamp;
        // now and then a request out of start order
        if ($urandom_range(0, 14) == 0) begin
          s = (stamp > 20000) ? stamp - $urandom_range(0, 20000) : '0;
        end
        case ($urandom_range(0, 9))
          0:       l = '0;
          1:       l = '1;
          2:       l = LOAD_W'($urandom);
          default: l = LOAD_W'($urandom_range(0, 20000));
        endcase
        queue_job(s, l);
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset count of 16: every server ties at zero
    queue_report();
    queue_job(32'd0, 16'd0);
    settle();

    set_servers(5'd2);
    queue_report();
    queue_job(32'd0, 16'd0);
    queue_job(32'd0, 16'hFFFF);
    queue_job(32'd0, 16'd10);
    queue_job(32'd5, 16'd3);        // both busy: drop
    queue_job(32'd10, 16'd7);       // free time equal to start: take
    queue_report();
    queue_job(32'hFFFF_FFFF, 16'hFFFF);
    queue_job(32'd100, 16'd1);      // behind the others in time: drop
    queue_report();
    settle();

    // top total sits on server 2, outside the active pool
    set_servers(5'd1);
    queue_report();
    queue_job(32'd70000, 16'd0);
    queue_report();
    settle();

    stamp = 32'd70000;
    set_servers(5'd5);
    random_run(25);
    settle();

    set_servers(5'd16);
    hold_armed = 1'b1;
    random_run(25);
    settle();

    set_servers(5'd0);
    random_run(25);
    settle();

    set_servers(5'd31);
    random_run(25);
    settle();

    set_servers(5'd9);
    random_run(25);
    settle();

    set_servers(5'd16);
    quiet = 1'b1;
    random_run(25);
    settle();

    if (outcome_q.size() != 0) begin
      $error("%0d results never arrived", outcome_q.size());
      fails++;
    end
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
